// ===== sv/bgft_pkg.sv =====
// ----------------------------------------------------------------------------
// bgft_pkg
// Shared constants for the battery gauge: register indexes, reciprocals for
// the constant divides and the state-of-charge curve.
// ----------------------------------------------------------------------------
package bgft_pkg;

   // csr register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_IS_MV = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALID_MIN    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALID_MAX    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TREND_STEP   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONFIRM      = 3'd4;
   localparam int CSR_DATA_W = 13;

   // reset values of the registers
   localparam logic [12:0] VALID_MIN_RST  = 13'd2800;
   localparam logic [12:0] VALID_MAX_RST  = 13'd4350;
   localparam logic [7:0]  TREND_STEP_RST = 8'd5;
   localparam logic [7:0]  CONFIRM_RST    = 8'd2;

   // raw code scale: pin mV = floor(code * 3300 / 4095)
   localparam logic [11:0] ADC_FULL_MV = 12'd3300;
   // ceil(2^36 / 4095), exact for products below 2^24
   localparam logic [24:0] RECIP_4095  = 25'd16781314;
   localparam int          RECIP_4095_SH = 36;
   // ceil(2^26 / 5), exact for operands below 2^26
   localparam logic [23:0] RECIP_5     = 24'd13421773;
   localparam int          RECIP_5_SH  = 26;

   localparam logic signed [7:0] PCT_INVALID = -8'sd1;

   // state-of-charge curve, ten points
   localparam int CURVE_N = 10;
   localparam logic [12:0] CURVE_MV [CURVE_N] = '{
      13'd3200, 13'd3400, 13'd3500, 13'd3600, 13'd3700,
      13'd3800, 13'd3900, 13'd4000, 13'd4100, 13'd4200
   };
   localparam logic [6:0] CURVE_PCT [CURVE_N] = '{
      7'd0, 7'd5, 7'd10, 7'd20, 7'd35, 7'd50, 7'd65, 7'd80, 7'd92, 7'd100
   };
   // segment k (ending at point k): rise * ceil(2^17 / 100); a span of 200
   // takes one more shift. Index 0 is unused.
   localparam logic [14:0] CURVE_COEF [CURVE_N] = '{
      15'd0, 15'd6555, 15'd6555, 15'd13110, 15'd19665,
      15'd19665, 15'd19665, 15'd19665, 15'd15732, 15'd10488
   };
   localparam logic [4:0] CURVE_SHIFT [CURVE_N] = '{
      5'd17, 5'd18, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17
   };

endpackage

// ===== sv/battery_gauge_filter_trend_top.sv =====
// Throughput: one request per cycle unless the result side stalls; five
// registered stages, the average and trend state update in a single stage,
// so items follow back to back.
// Reset (synchronous, active high) clears stage valids, the average, the
// trend counters and charging, and loads the register reset values.
// ----------------------------------------------------------------------------
// battery_gauge_filter_trend_top
// Battery voltage gauge: sample scaling, exponential average, charge trend
// detection and piecewise-linear state of charge.
// ----------------------------------------------------------------------------
module battery_gauge_filter_trend_top
   import bgft_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [11:0]            req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [12:0]            rsp_battery_mv,
   output logic signed [7:0]      rsp_percent,
   output logic                   rsp_charging,
   output logic                   rsp_valid_res,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration
   logic        is_mv_ff, is_mv_in;
   logic [12:0] vmin_ff, vmin_in;
   logic [12:0] vmax_ff, vmax_in;
   logic [7:0]  step_ff, step_in;
   logic [7:0]  confirm_ff, confirm_in;

   // stage valids
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic rsp_valid_ff, rsp_valid_in;

   // filter and trend state
   logic        seeded_ff, seeded_in;
   logic [20:0] avg_ff, avg_in;
   logic        chg_ff, chg_in;
   logic [7:0]  rise_ff, rise_in;
   logic [7:0]  fall_ff, fall_in;

   // payload
   logic [11:0] sample1_ff;
   logic [11:0] sample2_ff;
   logic [23:0] prod2_ff, prod2_in;
   logic [12:0] batt3_ff, batt3_in;
   logic [12:0] volt4_ff, volt4_in;
   logic        valid4_ff, valid4_in;
   logic        chg4_ff, chg4_in;
   logic [12:0] rsp_volt_ff;
   logic signed [7:0] rsp_pct_ff, rsp_pct_in;
   logic        rsp_chg_ff, rsp_valid_res_ff;

   // flow control
   logic rsp_free, s4_free, s3_free, s2_free, s1_free;
   logic en1, en2, en3, en4, accept;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign en4      = v4_ff && rsp_free;
   assign s4_free  = !v4_ff || rsp_free;
   assign en3      = v3_ff && s4_free;
   assign s3_free  = !v3_ff || s4_free;
   assign en2      = v2_ff && s3_free;
   assign s2_free  = !v2_ff || s3_free;
   assign en1      = v1_ff && s2_free;
   assign s1_free  = !v1_ff || s2_free;
   assign req_stall = !s1_free;
   assign accept   = req_valid && s1_free;

   always_comb begin
      v1_in = accept ? 1'b1 : (en1 ? 1'b0 : v1_ff);
      v2_in = en1 ? 1'b1 : (en2 ? 1'b0 : v2_ff);
      v3_in = en2 ? 1'b1 : (en3 ? 1'b0 : v3_ff);
      v4_in = en3 ? 1'b1 : (en4 ? 1'b0 : v4_ff);
      rsp_valid_in = en4 ? 1'b1 : ((rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff);
   end

   // register writes
   always_comb begin
      is_mv_in   = is_mv_ff;
      vmin_in    = vmin_ff;
      vmax_in    = vmax_ff;
      step_in    = step_ff;
      confirm_in = confirm_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLE_IS_MV: is_mv_in   = csr_wdata[0];
            CSR_VALID_MIN:    vmin_in    = csr_wdata[12:0];
            CSR_VALID_MAX:    vmax_in    = csr_wdata[12:0];
            CSR_TREND_STEP:   step_in    = csr_wdata[7:0];
            CSR_CONFIRM:      confirm_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // stage 1: scale raw code by full-scale millivolts
   assign prod2_in = 24'(sample1_ff) * 24'(ADC_FULL_MV);

   // stage 2: divide by 4095 (unless samples are mV), double to battery mV
   logic [48:0] recip_prod;
   logic [11:0] pin_mv;
   assign recip_prod = 49'(prod2_ff) * 49'(RECIP_4095);
   assign pin_mv     = is_mv_ff ? sample2_ff : recip_prod[RECIP_4095_SH+11:RECIP_4095_SH];
   assign batt3_in   = {pin_mv, 1'b0};

   // stage 3: average update, validity window and trend streaks
   logic [23:0]        avg_sum;
   logic [47:0]        div5_prod;
   logic [20:0]        avg_new, avg_old;
   logic [20:0]        round_sum;
   logic signed [21:0] change, thr;
   logic               in_window;

   always_comb begin
      avg_sum   = 24'({avg_ff, 2'b00}) + 24'({batt3_ff, 8'h00});
      div5_prod = 48'(avg_sum) * 48'(RECIP_5);
      avg_new   = seeded_ff ? div5_prod[RECIP_5_SH+20:RECIP_5_SH] : {batt3_ff, 8'h00};
      avg_old   = seeded_ff ? avg_ff : avg_new;
      change    = $signed({1'b0, avg_new}) - $signed({1'b0, avg_old});
      thr       = $signed(22'({step_ff, 8'h00}));
      round_sum = avg_new + 21'd128;
      volt4_in  = round_sum[20:8];
      in_window = (volt4_in >= vmin_ff) && (volt4_in <= vmax_ff);

      seeded_in = seeded_ff;
      avg_in    = avg_ff;
      rise_in   = rise_ff;
      fall_in   = fall_ff;
      chg_in    = chg_ff;
      if (en3) begin
         seeded_in = 1'b1;
         avg_in    = avg_new;
         rise_in   = 8'd0;
         fall_in   = 8'd0;
         if (in_window) begin
            if (change >= thr) begin
               rise_in = (rise_ff == 8'hFF) ? rise_ff : rise_ff + 8'd1;
            end else if (change <= -thr) begin
               fall_in = (fall_ff == 8'hFF) ? fall_ff : fall_ff + 8'd1;
            end
            if (rise_in >= confirm_ff) begin
               chg_in = 1'b1;
            end else if (fall_in >= confirm_ff) begin
               chg_in = 1'b0;
            end
         end
      end
      valid4_in = in_window;
      chg4_in   = in_window && chg_in;
   end

   // stage 4: state of charge from the curve
   logic [3:0]  seg;
   logic [3:0]  base;
   logic [7:0]  delta;
   logic [22:0] seg_prod;
   logic [22:0] seg_frac;
   logic [6:0]  pct;

   always_comb begin
      seg = 4'd1;
      for (int j = 1; j < CURVE_N - 1; j++) begin
         if (volt4_ff > CURVE_MV[j]) begin
            seg = seg + 4'd1;
         end
      end
      base     = seg - 4'd1;
      delta    = 8'(volt4_ff - CURVE_MV[base]);
      seg_prod = 23'(delta) * 23'(CURVE_COEF[seg]);
      seg_frac = seg_prod >> CURVE_SHIFT[seg];
      if (volt4_ff <= CURVE_MV[0]) begin
         pct = CURVE_PCT[0];
      end else if (volt4_ff >= CURVE_MV[CURVE_N-1]) begin
         pct = CURVE_PCT[CURVE_N-1];
      end else begin
         pct = CURVE_PCT[base] + seg_frac[6:0];
      end
      rsp_pct_in = valid4_ff ? $signed({1'b0, pct}) : PCT_INVALID;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         is_mv_ff     <= 1'b0;
         vmin_ff      <= VALID_MIN_RST;
         vmax_ff      <= VALID_MAX_RST;
         step_ff      <= TREND_STEP_RST;
         confirm_ff   <= CONFIRM_RST;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seeded_ff    <= 1'b0;
         avg_ff       <= '0;
         chg_ff       <= 1'b0;
         rise_ff      <= '0;
         fall_ff      <= '0;
      end else begin
         is_mv_ff     <= is_mv_in;
         vmin_ff      <= vmin_in;
         vmax_ff      <= vmax_in;
         step_ff      <= step_in;
         confirm_ff   <= confirm_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         rsp_valid_ff <= rsp_valid_in;
         seeded_ff    <= seeded_in;
         avg_ff       <= avg_in;
         chg_ff       <= chg_in;
         rise_ff      <= rise_in;
         fall_ff      <= fall_in;
      end
   end

   // payload registers, advance with their stage
   always_ff @(posedge clock) begin
      if (accept) begin
         sample1_ff <= req_sample;
      end
      if (en1) begin
         prod2_ff   <= prod2_in;
         sample2_ff <= sample1_ff;
      end
      if (en2) begin
         batt3_ff <= batt3_in;
      end
      if (en3) begin
         volt4_ff  <= volt4_in;
         valid4_ff <= valid4_in;
         chg4_ff   <= chg4_in;
      end
      if (en4) begin
         rsp_volt_ff      <= volt4_ff;
         rsp_pct_ff       <= rsp_pct_in;
         rsp_chg_ff       <= chg4_ff;
         rsp_valid_res_ff <= valid4_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_battery_mv = rsp_volt_ff;
   assign rsp_percent    = rsp_pct_ff;
   assign rsp_charging   = rsp_chg_ff;
   assign rsp_valid_res  = rsp_valid_res_ff;

endmodule

// ===== sv/bgft_checker.sv =====
// ----------------------------------------------------------------------------
// bgft_checker
// Port-level checks on the battery gauge results.
// ----------------------------------------------------------------------------
module bgft_checker
   import bgft_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [12:0]            rsp_battery_mv,
   input logic signed [7:0]      rsp_percent,
   input logic                   rsp_charging,
   input logic                   rsp_valid_res
);

   // invalid result carries the invalid percent and no charging
   a_invalid_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_percent == PCT_INVALID && !rsp_charging)
      else $error("invalid result with percent or charging set");

   // valid result has percent in 0..100
   a_percent_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> !rsp_percent[7] && rsp_percent <= 8'sd100)
      else $error("percent out of range");

   // voltage never exceeds twice the top pin voltage
   a_volt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_battery_mv <= 13'd8190)
      else $error("voltage out of range");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_battery_mv)
         && $stable(rsp_percent) && $stable(rsp_charging) && $stable(rsp_valid_res))
      else $error("stalled result changed");

endmodule

bind battery_gauge_filter_trend_top bgft_checker u_bgft_checker (.*);

// ===== dv/battery_gauge_filter_trend_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// battery_gauge_filter_trend_top_tb
// Drives ADC samples into the battery gauge under changing register settings
// and random gaps on the request side and stalls on the result side. A tracker
// predicts each reading from its own copy of the average, trend streaks and
// charging state, and checks every reading field by field in arrival order.
// ----------------------------------------------------------------------------
module battery_gauge_filter_trend_top_tb
   import bgft_pkg::*;
();

   typedef struct {
      logic [12:0]       battery_mv;
      logic signed [7:0] percent;
      logic              charging;
      logic              valid_res;
   } gauge_reading_type;

   class gauge_tracker_type;
      bit                 sample_is_mv;
      bit [12:0]          valid_min;
      bit [12:0]          valid_max;
      bit [7:0]           trend_step;
      bit [7:0]           confirm_len;
      bit                 seeded;
      bit [20:0]          avg_q8;
      bit                 charging;
      int unsigned        rise_run;
      int unsigned        fall_run;
      gauge_reading_type  pending_readings[$];
      int                 errors;
      int                 checked;

      function new();
         sample_is_mv = 1'b0;
         valid_min    = 13'd2800;
         valid_max    = 13'd4350;
         trend_step   = 8'd5;
         confirm_len  = 8'd2;
         seeded       = 1'b0;
         avg_q8       = '0;
         charging     = 1'b0;
         rise_run     = 0;
         fall_run     = 0;
         errors       = 0;
         checked      = 0;
      endfunction

      function void apply_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SAMPLE_IS_MV: sample_is_mv = data[0];
            CSR_VALID_MIN:    valid_min    = data;
            CSR_VALID_MAX:    valid_max    = data;
            CSR_TREND_STEP:   trend_step   = data[7:0];
            CSR_CONFIRM:      confirm_len  = data[7:0];
            default: ;
         endcase
      endfunction

      // piecewise-linear state of charge, truncating between knees
      function int soc_percent(int mv);
         int knee_mv[10];
         int knee_pct[10];
         int pct;
         knee_mv  = '{3200, 3400, 3500, 3600, 3700, 3800, 3900, 4000, 4100, 4200};
         knee_pct = '{0, 5, 10, 20, 35, 50, 65, 80, 92, 100};
         if (mv <= knee_mv[0]) return knee_pct[0];
         if (mv >= knee_mv[9]) return knee_pct[9];
         pct = 100;
         // walk down so the lowest knee at or above mv wins
         for (int k = 9; k >= 1; k--) begin
            if (mv <= knee_mv[k]) begin
               pct = knee_pct[k-1] + ((mv - knee_mv[k-1]) * (knee_pct[k] - knee_pct[k-1]))
                     / (knee_mv[k] - knee_mv[k-1]);
            end
         end
         return pct;
      endfunction

      function void take_sample(logic [11:0] code);
         int unsigned       pin_mv;
         int unsigned       batt_mv;
         int unsigned       old_avg;
         int unsigned       next_avg;
         int unsigned       volt;
         int                change;
         int                thr;
         gauge_reading_type r;
         pin_mv  = sample_is_mv ? 32'(code) : (32'(code) * 3300) / 4095;
         batt_mv = 2 * pin_mv;
         old_avg = avg_q8;
         if (!seeded) begin
            seeded   = 1'b1;
            next_avg = batt_mv * 256;
            old_avg  = next_avg;
         end else begin
            next_avg = (4 * old_avg + batt_mv * 256) / 5;
         end
         avg_q8       = next_avg[20:0];
         change       = int'(32'(avg_q8)) - int'(old_avg);
         volt         = (32'(avg_q8) + 128) >> 8;
         r.battery_mv = volt[12:0];
         if (volt < valid_min || volt > valid_max) begin
            rise_run    = 0;
            fall_run    = 0;
            r.percent   = -8'sd1;
            r.charging  = 1'b0;
            r.valid_res = 1'b0;
         end else begin
            thr = int'(trend_step) * 256;
            if (change >= thr) begin
               if (rise_run < 255) rise_run++;
               fall_run = 0;
            end else if (change <= -thr) begin
               if (fall_run < 255) fall_run++;
               rise_run = 0;
            end else begin
               rise_run = 0;
               fall_run = 0;
            end
            if (rise_run >= confirm_len) charging = 1'b1;
            else if (fall_run >= confirm_len) charging = 1'b0;
            r.percent   = 8'(soc_percent(int'(volt)));
            r.charging  = charging;
            r.valid_res = 1'b1;
         end
         pending_readings.push_back(r);
      endfunction

      function void check_reading(gauge_reading_type got);
         gauge_reading_type want;
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected reading battery_mv=%0d percent=%0d charging=%0b valid=%0b",
                     $time, got.battery_mv, got.percent, got.charging, got.valid_res);
            errors++;
            return;
         end
         want = pending_readings.pop_front();
         checked++;
         if (got.battery_mv !== want.battery_mv) begin
            $display("%0t: battery_mv expected %0d, got %0d",
                     $time, want.battery_mv, got.battery_mv);
            errors++;
         end
         if (got.percent !== want.percent) begin
            $display("%0t: percent expected %0d, got %0d", $time, want.percent, got.percent);
            errors++;
         end
         if (got.charging !== want.charging) begin
            $display("%0t: charging expected %0b, got %0b", $time, want.charging, got.charging);
            errors++;
         end
         if (got.valid_res !== want.valid_res) begin
            $display("%0t: valid_res expected %0b, got %0b",
                     $time, want.valid_res, got.valid_res);
            errors++;
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_ITEMS   = 400;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [11:0]            req_sample;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [12:0]            rsp_battery_mv;
   logic signed [7:0]      rsp_percent;
   logic                   rsp_charging;
   logic                   rsp_valid_res;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   gauge_tracker_type tracker;
   bit           req_gaps_on;
   bit           rsp_stalls_on;
   int           hold_rsp_request;
   int           requests_sent;
   int           settings_used;
   int           ramp_mv;
   int           ramp_dir;
   int           ramp_slope;
   int           ramp_left;

   battery_gauge_filter_trend_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_battery_mv (rsp_battery_mv),
      .rsp_percent    (rsp_percent),
      .rsp_charging   (rsp_charging),
      .rsp_valid_res  (rsp_valid_res),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side: check readings, stall at random or hold off on request
   initial begin : rsp_side
      int                stall_left;
      int                r;
      gauge_reading_type got;
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            got.battery_mv = rsp_battery_mv;
            got.percent    = rsp_percent;
            got.charging   = rsp_charging;
            got.valid_res  = rsp_valid_res;
            tracker.check_reading(got);
         end
         if (hold_rsp_request > 0) begin
            stall_left       = hold_rsp_request;
            hold_rsp_request = 0;
         end else if (stall_left == 0 && rsp_stalls_on) begin
            r = $urandom_range(0, 99);
            if (r < 25) stall_left = $urandom_range(1, 3);
            else if (r < 28) stall_left = $urandom_range(15, 40);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d readings outstanding",
                     $time, idle_cycles, tracker.pending_readings.size());
            $display("FAIL battery_gauge_filter_trend_top");
            $finish;
         end
      end
   end

   function automatic int pick_gap(bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // mostly ramps around the battery range, with a share of raw noise
   function automatic logic [11:0] shaped_sample(bit mv_mode);
      int v;
      if ($urandom_range(0, 99) < 8) return 12'($urandom_range(0, 4095));
      if (ramp_left == 0) begin
         ramp_left  = $urandom_range(4, 40);
         ramp_dir   = int'($urandom_range(0, 2)) - 1;
         ramp_slope = $urandom_range(0, 50);
         if ($urandom_range(0, 3) == 0) ramp_mv = $urandom_range(2400, 4800);
      end
      ramp_left--;
      ramp_mv = ramp_mv + ramp_dir * ramp_slope + int'($urandom_range(0, 10)) - 5;
      if (ramp_mv < 0) ramp_mv = 0;
      if (ramp_mv > 8190) ramp_mv = 8190;
      v = mv_mode ? ramp_mv / 2 : (ramp_mv * 4095) / 6600;
      if (v > 4095) v = 4095;
      return 12'(v);
   endfunction

   task automatic send_sample(logic [11:0] s);
      int gap;
      gap = pick_gap(req_gaps_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.take_sample(s);
      requests_sent++;
   endtask

   // drop valid and wait for every reading, then let the pipe go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, int data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(data);
      @(posedge clock);
      tracker.apply_reg(idx, CSR_DATA_W'(data));
   endtask

   task automatic configure(bit mv_mode, int vmin, int vmax, int step, int confirm);
      settle();
      csr_write(CSR_SAMPLE_IS_MV, mv_mode);
      csr_write(CSR_VALID_MIN, vmin);
      csr_write(CSR_VALID_MAX, vmax);
      csr_write(CSR_TREND_STEP, step);
      csr_write(CSR_CONFIRM, confirm);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic random_phase(int n_items);
      bit mv_mode;
      int vmin;
      int vmax;
      int step;
      int confirm;
      int r;
      mv_mode = $urandom_range(0, 1);
      r = $urandom_range(0, 9);
      if (r < 7) begin
         vmin = $urandom_range(2400, 3300);
         vmax = $urandom_range(3900, 4700);
      end else if (r == 7) begin
         vmin = 0;
         vmax = 8191;
      end else if (r == 8) begin
         vmin = 8191;
         vmax = 0;
      end else begin
         vmin = $urandom_range(3000, 4000);
         vmax = vmin;
      end
      r = $urandom_range(0, 9);
      step = (r < 7) ? $urandom_range(1, 40) : (r == 7) ? 0 : (r == 8) ? 255 :
             $urandom_range(41, 254);
      r = $urandom_range(0, 9);
      confirm = (r < 7) ? $urandom_range(1, 6) : (r == 7) ? 1 : (r == 8) ? 255 : 0;
      configure(mv_mode, vmin, vmax, step, confirm);
      req_gaps_on   = $urandom_range(0, 3) != 0;
      rsp_stalls_on = $urandom_range(0, 3) != 0;
      for (int i = 0; i < n_items; i++) begin
         send_sample(shaped_sample(mv_mode));
      end
   endtask

   initial begin : stimulus
      int       random_start;
      int       hold_mv;
      tracker          = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample       = '0;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      hold_rsp_request = 0;
      req_gaps_on      = 1'b1;
      rsp_stalls_on    = 1'b1;
      requests_sent    = 0;
      settings_used    = 0;
      ramp_mv          = 3600;
      ramp_dir         = 0;
      ramp_slope       = 0;
      ramp_left        = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, raw codes: seed at zero, climb through the window and past
      // it, fall back out below, then rise again; hits both curve ends
      send_sample(12'd0);
      repeat (6) send_sample(12'd4095);
      repeat (5) send_sample(12'd1000);
      repeat (3) send_sample(12'd2048);

      // calibrated millivolts, full window, zero step and zero confirmation
      configure(1'b1, 0, 8191, 0, 0);
      send_sample(12'd4095);
      send_sample(12'd4095);
      send_sample(12'd0);
      send_sample(12'd0);

      // empty window: every reading invalid
      configure(1'b0, 8191, 0, 255, 255);
      send_sample(12'd2048);
      send_sample(12'd4095);
      send_sample(12'd0);

      // receiver holds off long while requests keep coming, then drain fully
      configure(1'b0, 2800, 4350, 5, 1);
      req_gaps_on      = 1'b0;
      hold_rsp_request = 150;
      repeat (40) send_sample(shaped_sample(1'b0));
      settle();
      req_gaps_on = 1'b1;
      repeat (20) send_sample(shaped_sample(1'b0));

      // steady input with zero step: changes settle to zero and the rise
      // streak runs into saturation
      configure(1'b1, 0, 8191, 0, 255);
      hold_mv = (int'(tracker.avg_q8) + 256) / 512;
      if (hold_mv > 4095) hold_mv = 4095;
      repeat (300) send_sample(12'(hold_mv));

      random_start = requests_sent;
      while (requests_sent - random_start < RANDOM_ITEMS) begin
         random_phase($urandom_range(30, 90));
      end

      settle();
      $display("Ran %0d requests across %0d register settings; %0d readings checked.",
               requests_sent, settings_used + 1, tracker.checked);
      $display("Covered both sample modes, window edges, zero and saturated streaks.");
      if (tracker.errors == 0 && tracker.pending_readings.size() == 0) begin
         $display("PASS battery_gauge_filter_trend_top");
      end else begin
         $display("%0d mismatches, %0d readings missing",
                  tracker.errors, tracker.pending_readings.size());
         $display("FAIL battery_gauge_filter_trend_top");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/bgft_pkg.sv
sv/battery_gauge_filter_trend_top.sv
sv/bgft_checker.sv
dv/battery_gauge_filter_trend_top_tb.sv
